// ----- rtl/svra_pkg.sv -----
// shared types, constants and the arctangent table for the rotation angle unit
package svra_pkg;

  // datapath widths
  localparam int DW     = 60;  // dot and cross products after prescale
  localparam int MAG_W  = 59;  // combined magnitude used for normalisation
  localparam int CW     = 62;  // cordic x and y
  localparam int ZW     = 26;  // cordic angle, degrees with 16 fraction bits
  localparam int AW     = 16;  // result angle, degrees with 7 fraction bits
  localparam int SNAP_W = 10;

  // normalisation shift steps: 32, 16, 8, 4, 2, 1
  localparam int NORM_STEPS = 6;

  // angle codes with 7 fraction bits
  localparam logic [AW:0] ANGLE_FULL    = 17'd46080;
  localparam logic [AW:0] ANGLE_HALF    = 17'd23040;
  localparam logic [AW:0] ANGLE_QUARTER = 17'd11520;
  localparam logic [AW:0] ANGLE_3QUART  = 17'd34560;

  // accumulator constants with 16 fraction bits
  localparam logic signed [ZW-1:0] Z_HALF     = 26'sd11796480;
  localparam logic signed [ZW-1:0] Z_RND      = 26'sd256;
  localparam logic signed [ZW-1:0] Z_WRAP_RND = 26'sd23593216;

  // register map
  localparam logic                REG_SNAP_WINDOW = 1'b0;
  localparam logic [SNAP_W-1:0]   SNAP_RESET      = 10'd10;

  // per-item sideband carried alongside the datapath
  typedef struct packed {
    logic          degen;
    logic          fixed;
    logic [AW-1:0] fixed_angle;
  } side_t;

  // atan(2^-i) in degrees scaled by 2^16, rounded
  function automatic logic signed [ZW-1:0] svra_atan(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = 26'sd2949120;
      1:       v = 26'sd1740967;
      2:       v = 26'sd919879;
      3:       v = 26'sd466945;
      4:       v = 26'sd234379;
      5:       v = 26'sd117304;
      6:       v = 26'sd58666;
      7:       v = 26'sd29335;
      8:       v = 26'sd14668;
      9:       v = 26'sd7334;
      10:      v = 26'sd3667;
      11:      v = 26'sd1833;
      12:      v = 26'sd917;
      13:      v = 26'sd458;
      14:      v = 26'sd229;
      15:      v = 26'sd115;
      16:      v = 26'sd57;
      17:      v = 26'sd29;
      18:      v = 26'sd14;
      19:      v = 26'sd7;
      20:      v = 26'sd4;
      21:      v = 26'sd2;
      22:      v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/svra_norm_stage.sv -----
// one step of the normalising left shift for dot and cross
module svra_norm_stage #(
  parameter int SHIFT = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  svra_pkg::side_t                 side_i,
  input  logic signed [svra_pkg::DW-1:0]  d_i,
  input  logic signed [svra_pkg::DW-1:0]  c_i,
  input  logic [svra_pkg::MAG_W-1:0]      mag_i,
  output logic                            valid_o,
  output svra_pkg::side_t                 side_o,
  output logic signed [svra_pkg::DW-1:0]  d_o,
  output logic signed [svra_pkg::DW-1:0]  c_o,
  output logic [svra_pkg::MAG_W-1:0]      mag_o
);
  import svra_pkg::*;

  logic                   valid_q;
  side_t                  side_q;
  logic signed [DW-1:0]   d_q, d_d;
  logic signed [DW-1:0]   c_q, c_d;
  logic [MAG_W-1:0]       mag_q, mag_d;

  // shift when the top bits of the magnitude are clear
  always_comb begin
    if (mag_i[MAG_W-1 -: SHIFT] == '0) begin
      d_d   = d_i <<< SHIFT;
      c_d   = c_i <<< SHIFT;
      mag_d = mag_i << SHIFT;
    end else begin
      d_d   = d_i;
      c_d   = c_i;
      mag_d = mag_i;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    side_q <= side_i;
    d_q    <= d_d;
    c_q    <= c_d;
    mag_q  <= mag_d;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign d_o     = d_q;
  assign c_o     = c_q;
  assign mag_o   = mag_q;

endmodule

// ----- rtl/svra_cordic_cell.sv -----
// one vectoring cordic micro-rotation with its pipeline register
module svra_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  svra_pkg::side_t                 side_i,
  input  logic signed [svra_pkg::CW-1:0]  x_i,
  input  logic signed [svra_pkg::CW-1:0]  y_i,
  input  logic signed [svra_pkg::ZW-1:0]  z_i,
  output logic                            valid_o,
  output svra_pkg::side_t                 side_o,
  output logic signed [svra_pkg::CW-1:0]  x_o,
  output logic signed [svra_pkg::CW-1:0]  y_o,
  output logic signed [svra_pkg::ZW-1:0]  z_o
);
  import svra_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = svra_atan(STAGE);

  logic                 valid_q;
  side_t                side_q;
  logic signed [CW-1:0] x_q, x_d;
  logic signed [CW-1:0] y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;

  // rotate towards the x axis, direction from the sign of y
  always_comb begin
    if (!y_i[CW-1]) begin
      x_d = x_i + (y_i >>> STAGE);
      y_d = y_i - (x_i >>> STAGE);
      z_d = z_i + ATAN;
    end else begin
      x_d = x_i - (y_i >>> STAGE);
      y_d = y_i + (x_i >>> STAGE);
      z_d = z_i - ATAN;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    side_q <= side_i;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

// ----- rtl/signed_vector_rotation_angle_unit.sv -----
// top level: products, normalisation, cordic chain, wrap, round and snap
// done_o is the taken start carried through every stage register of the chain below
// throughput: one vector pair per cycle, busy stays low, set by the fully pipelined cell chain
// every stage is one register; the chain holds 12 + CORDIC_STAGES pairs in flight
// the result is shown for one cycle on done_o; the receiver cannot stall
// reset clears all valid flags and sets snap_window to 10; no clearing pass is needed
module signed_vector_rotation_angle_unit #(
  parameter int COMPONENT_BITS = 16,
  parameter int CORDIC_STAGES  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COMPONENT_BITS-1:0] first_x_i,
  input  logic signed [COMPONENT_BITS-1:0] first_y_i,
  input  logic signed [COMPONENT_BITS-1:0] second_x_i,
  input  logic signed [COMPONENT_BITS-1:0] second_y_i,
  // result channel
  output logic                             done_o,
  output logic [svra_pkg::AW-1:0]          angle_degrees_o,
  output logic                             degenerate_o,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import svra_pkg::*;

  localparam int PW  = 2 * COMPONENT_BITS;
  localparam int PRE = (PW > 58) ? (PW - 58) : 0;
  localparam int SW  = PW - PRE;
  localparam int LAT = 12 + CORDIC_STAGES;

  logic accept;
  assign accept = start && !busy;
  assign busy   = 1'b0;

  // configuration register
  logic [SNAP_W-1:0] snap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_q <= SNAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SNAP_WINDOW)) begin
      snap_q <= pwdata[SNAP_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SNAP_WINDOW) ? {{(32-SNAP_W){1'b0}}, snap_q} : 32'd0;

  // stage 1: four products and the zero-length test
  logic signed [PW-1:0] prod_q [4];
  logic signed [PW-1:0] prod_d [4];
  logic                 v1_q, degen1_q, degen1_d;

  always_comb begin
    prod_d[0] = PW'(first_x_i) * PW'(second_x_i);
    prod_d[1] = PW'(first_y_i) * PW'(second_y_i);
    prod_d[2] = PW'(first_x_i) * PW'(second_y_i);
    prod_d[3] = PW'(first_y_i) * PW'(second_x_i);
    degen1_d  = ((first_x_i == '0) && (first_y_i == '0)) ||
                ((second_x_i == '0) && (second_y_i == '0));
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    degen1_q <= degen1_d;
  end

  // stage 2: prescale and form dot and cross
  logic signed [PW-1:0] shr  [4];
  logic signed [SW-1:0] term [4];
  logic signed [DW-1:0] ext  [4];
  logic signed [DW-1:0] dot_q, dot_d, crs_q, crs_d;
  logic                 v2_q, degen2_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      shr[k]  = prod_q[k] >>> PRE;
      term[k] = $signed(shr[k][SW-1:0]);
      ext[k]  = DW'(term[k]);
    end
    dot_d = ext[0] + ext[1];
    crs_d = ext[2] - ext[3];
  end

  always_ff @(posedge clk_i) begin
    dot_q    <= dot_d;
    crs_q    <= crs_d;
    degen2_q <= degen1_q;
  end

  // stage 3: special angles and combined magnitude
  logic signed [DW-1:0] dabs, cabs;
  logic [DW-1:0]        mag_full;
  side_t                side3_d, side3_q;
  logic signed [DW-1:0] d3_q, c3_q;
  logic [MAG_W-1:0]     mag3_q;
  logic                 v3_q;

  always_comb begin
    dabs     = dot_q[DW-1] ? -dot_q : dot_q;
    cabs     = crs_q[DW-1] ? -crs_q : crs_q;
    mag_full = dabs | cabs;
    side3_d.degen       = degen2_q;
    side3_d.fixed       = 1'b1;
    side3_d.fixed_angle = '0;
    if (degen2_q || ((dot_q == '0) && (crs_q == '0))) begin
      side3_d.fixed_angle = '0;
    end else if (crs_q == '0) begin
      side3_d.fixed_angle = dot_q[DW-1] ? ANGLE_HALF[AW-1:0] : '0;
    end else if (dot_q == '0) begin
      side3_d.fixed_angle = crs_q[DW-1] ? ANGLE_3QUART[AW-1:0] : ANGLE_QUARTER[AW-1:0];
    end else begin
      side3_d.fixed = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    side3_q <= side3_d;
    d3_q    <= dot_q;
    c3_q    <= crs_q;
    mag3_q  <= mag_full[MAG_W-1:0];
  end

  // normalisation chain, largest shift first
  logic                 nv   [NORM_STEPS+1];
  side_t                ns   [NORM_STEPS+1];
  logic signed [DW-1:0] nd   [NORM_STEPS+1];
  logic signed [DW-1:0] nc   [NORM_STEPS+1];
  logic [MAG_W-1:0]     nmag [NORM_STEPS+1];

  assign nv[0]   = v3_q;
  assign ns[0]   = side3_q;
  assign nd[0]   = d3_q;
  assign nc[0]   = c3_q;
  assign nmag[0] = mag3_q;

  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    svra_norm_stage #(
      .SHIFT (1 << (NORM_STEPS - 1 - j))
    ) u_norm (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (nv[j]),
      .side_i  (ns[j]),
      .d_i     (nd[j]),
      .c_i     (nc[j]),
      .mag_i   (nmag[j]),
      .valid_o (nv[j+1]),
      .side_o  (ns[j+1]),
      .d_o     (nd[j+1]),
      .c_o     (nc[j+1]),
      .mag_o   (nmag[j+1])
    );
  end

  // pre-rotation into the right half plane
  logic signed [CW-1:0] xw, yw;
  logic signed [CW-1:0] xp_q, xp_d, yp_q, yp_d;
  logic signed [ZW-1:0] zp_q, zp_d;
  side_t                sp_q;
  logic                 vp_q;

  always_comb begin
    xw = CW'(nd[NORM_STEPS]);
    yw = CW'(nc[NORM_STEPS]);
    if (xw[CW-1]) begin
      xp_d = -xw;
      yp_d = -yw;
      zp_d = Z_HALF;
    end else begin
      xp_d = xw;
      yp_d = yw;
      zp_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    xp_q <= xp_d;
    yp_q <= yp_d;
    zp_q <= zp_d;
    sp_q <= ns[NORM_STEPS];
  end

  // cordic cell chain
  logic                 cv [CORDIC_STAGES+1];
  side_t                cs [CORDIC_STAGES+1];
  logic signed [CW-1:0] cx [CORDIC_STAGES+1];
  logic signed [CW-1:0] cy [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz [CORDIC_STAGES+1];

  assign cv[0] = vp_q;
  assign cs[0] = sp_q;
  assign cx[0] = xp_q;
  assign cy[0] = yp_q;
  assign cz[0] = zp_q;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    svra_cordic_cell #(
      .STAGE (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[i]),
      .side_i  (cs[i]),
      .x_i     (cx[i]),
      .y_i     (cy[i]),
      .z_i     (cz[i]),
      .valid_o (cv[i+1]),
      .side_o  (cs[i+1]),
      .x_o     (cx[i+1]),
      .y_o     (cy[i+1]),
      .z_o     (cz[i+1])
    );
  end

  // wrap into one turn and round to 7 fraction bits
  logic signed [ZW-1:0] zsum;
  logic [AW:0]          rr;
  logic [AW-1:0]        rw_q, rw_d;
  side_t                sf_q;
  logic                 vf_q;

  always_comb begin
    zsum = cz[CORDIC_STAGES] + (cz[CORDIC_STAGES][ZW-1] ? Z_WRAP_RND : Z_RND);
    rr   = {1'b0, zsum[ZW-2:9]};
    rw_d = (rr >= ANGLE_FULL) ? AW'(rr - ANGLE_FULL) : rr[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    rw_q <= rw_d;
    sf_q <= cs[CORDIC_STAGES];
  end

  // snap near 0 and 180 degrees, output register
  logic [AW-1:0] ang;
  logic [AW:0]   dist0, dist180, win;
  logic [AW-1:0] angle_q, angle_d;
  logic          degen_q, done_q;

  always_comb begin
    ang     = sf_q.fixed ? sf_q.fixed_angle : rw_q;
    win     = {{(AW+1-SNAP_W){1'b0}}, snap_q};
    dist0   = ({1'b0, ang} < (ANGLE_FULL - {1'b0, ang})) ? {1'b0, ang}
                                                        : (ANGLE_FULL - {1'b0, ang});
    dist180 = ({1'b0, ang} >= ANGLE_HALF) ? ({1'b0, ang} - ANGLE_HALF)
                                          : (ANGLE_HALF - {1'b0, ang});
    if (sf_q.degen || (dist0 <= win)) begin
      angle_d = '0;
    end else if (dist180 <= win) begin
      angle_d = ANGLE_HALF[AW-1:0];
    end else begin
      angle_d = ang;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
    degen_q <= sf_q.degen;
  end

  // valid flags of the fixed stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vp_q   <= 1'b0;
      vf_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= accept;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      vp_q   <= nv[NORM_STEPS];
      vf_q   <= cv[CORDIC_STAGES];
      done_q <= vf_q;
    end
  end

  assign done_o          = done_q;
  assign angle_degrees_o = angle_q;
  assign degenerate_o    = degen_q;

`ifndef SYNTHESIS
  // every accepted pair leaves the chain after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("accepted beat did not reach the result port on time");

  // nothing leaves the chain that was not accepted
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result beat without an accepted input");

  // a zero-length vector yields angle zero
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (angle_degrees_o == '0))
    else $error("degenerate beat with nonzero angle");

  // the angle stays inside one turn
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ({1'b0, angle_degrees_o} < ANGLE_FULL))
    else $error("angle beyond one full turn");
`endif

endmodule

// ----- tb/rotation_angle_checker.sv -----
`timescale 1ns / 100ps
// checker for the rotation angle unit: watches every beat, predicts angles and compares
module rotation_angle_checker #(
  parameter int         CORDIC_STAGES = 16,
  parameter logic [2:0] SNAP_ADDR     = 3'd0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic signed [15:0]        first_x_i,
  input  logic signed [15:0]        first_y_i,
  input  logic signed [15:0]        second_x_i,
  input  logic signed [15:0]        second_y_i,
  input  logic                      done_i,
  input  logic [svra_pkg::AW-1:0]   angle_degrees_i,
  input  logic                      degenerate_i,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic                      pready_i,
  input  logic [2:0]                paddr_i,
  input  logic [31:0]               pwdata_i,
  input  logic [31:0]               prdata_i,
  output int unsigned               mismatches_o,
  output int unsigned               outstanding_o,
  output int unsigned               results_seen_o
);

  localparam logic [9:0]  WINDOW_DEFAULT = 10'd10;
  localparam int unsigned TURN_FULL      = 46080;
  localparam int unsigned TURN_HALF      = 23040;
  localparam int unsigned TURN_QUARTER   = 11520;
  localparam int unsigned TURN_3QUARTER  = 34560;
  localparam longint      DEG_UNIT       = 65536;
  localparam longint      NORM_FLOOR     = 64'sd1 <<< 58;
  localparam int          LUT_LEN        = 24;
  localparam int          REPORT_MAX     = 10;

  typedef struct packed {
    logic [svra_pkg::AW-1:0] angle;
    logic                    degen;
  } angle_result_t;

  // arctangent of 2^-i in degrees, 16 fraction bits
  longint atan_lut [0:LUT_LEN-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  angle_result_t angle_due_q [$];
  logic [9:0]    snap_copy;
  int unsigned   mismatch_total;
  int unsigned   results_seen;

  assign mismatches_o   = mismatch_total;
  assign results_seen_o = results_seen;

  // expected angle and degenerate flag for one vector pair
  function automatic angle_result_t predict_angle(input logic signed [15:0] ax, ay, bx, by,
                                                  input logic [9:0] window);
    angle_result_t res;
    longint        dot, crs, mag, x, y, z, t;
    int            k, idx;
    int unsigned   r, dist0, dist180;
    res.angle = '0;
    res.degen = 1'b0;
    if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
      res.degen = 1'b1;
      return res;
    end
    dot = longint'(ax) * longint'(bx) + longint'(ay) * longint'(by);
    crs = longint'(ax) * longint'(by) - longint'(ay) * longint'(bx);
    if (dot == 0 && crs == 0) begin
      r = 0;
    end else if (crs == 0) begin
      r = (dot > 0) ? 0 : TURN_HALF;
    end else if (dot == 0) begin
      r = (crs > 0) ? TURN_QUARTER : TURN_3QUARTER;
    end else begin
      // normalise so the larger magnitude sits just under the top
      mag = (dot < 0) ? -dot : dot;
      if (((crs < 0) ? -crs : crs) > mag) mag = (crs < 0) ? -crs : crs;
      k = 0;
      while (mag < NORM_FLOOR && k < 64) begin
        mag = mag <<< 1;
        k++;
      end
      x = dot <<< k;
      y = crs <<< k;
      z = 0;
      // left half plane: turn by 180 first
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 180 * DEG_UNIT;
      end
      // vectoring iterations
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        idx = (i < LUT_LEN) ? i : LUT_LEN - 1;
        if (y >= 0) begin
          t = x + (y >>> idx);
          y = y - (x >>> idx);
          z = z + atan_lut[idx];
        end else begin
          t = x - (y >>> idx);
          y = y + (x >>> idx);
          z = z - atan_lut[idx];
        end
        x = t;
      end
      if (z < 0) z = z + 360 * DEG_UNIT;
      r = 32'((z + 64'sd256) >>> 9);
      while (r >= TURN_FULL) r = r - TURN_FULL;
    end
    // snap near 0 first, then near 180
    dist0   = (r < TURN_FULL - r) ? r : TURN_FULL - r;
    dist180 = (r >= TURN_HALF) ? r - TURN_HALF : TURN_HALF - r;
    if (dist0 <= window) r = 0;
    else if (dist180 <= window) r = TURN_HALF;
    res.angle = 16'(r);
    return res;
  endfunction

  // count a mismatch, print only the first few
  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
    mismatch_total++;
    if (mismatch_total <= REPORT_MAX)
      $display("mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, exp_v, got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    angle_result_t due;
    if (!rst_ni) begin
      angle_due_q.delete();
      snap_copy     = WINDOW_DEFAULT;
      outstanding_o <= 0;
    end else begin
      // result beat against the oldest pending pair
      if (done_i === 1'b1) begin
        results_seen++;
        if (angle_due_q.size() == 0) begin
          report("result with no pair pending", 32'd0, 32'(angle_degrees_i));
        end else begin
          due = angle_due_q.pop_front();
          if (angle_degrees_i !== due.angle)
            report("angle_degrees", 32'(due.angle), 32'(angle_degrees_i));
          if (degenerate_i !== due.degen)
            report("degenerate", 32'(due.degen), 32'(degenerate_i));
        end
      end
      // command beat
      if (start_i && busy_i === 1'b0)
        angle_due_q.push_back(predict_angle(first_x_i, first_y_i, second_x_i, second_y_i,
                                            snap_copy));
      // register beat
      if (psel_i && penable_i && pready_i && paddr_i == SNAP_ADDR) begin
        if (pwrite_i) snap_copy = pwdata_i[9:0];
        else if (prdata_i !== {22'd0, snap_copy})
          report("snap_window readback", {22'd0, snap_copy}, prdata_i);
      end
      outstanding_o <= angle_due_q.size();
    end
  end

endmodule

// ----- tb/signed_vector_rotation_angle_unit_test.sv -----
`timescale 1ns / 100ps
// regression top for the rotation angle unit: clock, reset, stimulus and verdict
module signed_vector_rotation_angle_unit_test;
  import svra_pkg::*;

  localparam int         CORDIC_STAGES = 16;
  localparam int         PIPE_DEPTH    = 12 + CORDIC_STAGES;
  localparam int         CLK_PERIOD    = 10;
  localparam int         STALL_LIMIT   = 1000;
  localparam int         PHASE_ITEMS   = 225;
  localparam logic [2:0] SNAP_ADDR     = 3'(4 * int'(REG_SNAP_WINDOW));
  localparam logic [2:0] SPARE_ADDR    = 3'd4;
  localparam logic       APB_WRITE     = 1'b1;
  localparam logic       APB_READ      = 1'b0;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               start      = 1'b0;
  logic               busy;
  logic signed [15:0] first_x_i  = '0;
  logic signed [15:0] first_y_i  = '0;
  logic signed [15:0] second_x_i = '0;
  logic signed [15:0] second_y_i = '0;
  logic               done_o;
  logic [AW-1:0]      angle_degrees_o;
  logic               degenerate_o;
  logic               psel       = 1'b0;
  logic               penable    = 1'b0;
  logic               pwrite     = 1'b0;
  logic [2:0]         paddr      = '0;
  logic [31:0]        pwdata     = '0;
  logic [31:0]        prdata;
  logic               pready;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_seen;
  int unsigned pairs_sent    = 0;
  int unsigned window_writes = 0;
  int unsigned idle_cycles   = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  signed_vector_rotation_angle_unit #(
    .COMPONENT_BITS (16),
    .CORDIC_STAGES  (CORDIC_STAGES)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .first_x_i       (first_x_i),
    .first_y_i       (first_y_i),
    .second_x_i      (second_x_i),
    .second_y_i      (second_y_i),
    .done_o          (done_o),
    .angle_degrees_o (angle_degrees_o),
    .degenerate_o    (degenerate_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  rotation_angle_checker #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .SNAP_ADDR     (SNAP_ADDR)
  ) angle_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .first_x_i       (first_x_i),
    .first_y_i       (first_y_i),
    .second_x_i      (second_x_i),
    .second_y_i      (second_y_i),
    .done_i          (done_o),
    .angle_degrees_i (angle_degrees_o),
    .degenerate_i    (degenerate_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_i        (prdata),
    .mismatches_o    (mismatches),
    .outstanding_o   (outstanding),
    .results_seen_o  (results_seen)
  );

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1 || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("no beat for %0d cycles, run abandoned", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // uniform component in [lo, hi]
  function automatic logic signed [15:0] rand_span(input int lo, input int hi);
    return 16'(int'($urandom_range(0, hi - lo)) + lo);
  endfunction

  // component drawn from the edges of the range
  function automatic logic signed [15:0] rand_edge();
    case ($urandom_range(0, 5))
      0:       return -16'sd32768;
      1:       return -16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  // one command beat, held until the unit takes it
  task automatic send_pair(input logic signed [15:0] ax, ay, bx, by);
    start      <= 1'b1;
    first_x_i  <= ax;
    first_y_i  <= ay;
    second_x_i <= bx;
    second_y_i <= by;
    do @(posedge clk_i); while (busy !== 1'b0);
    pairs_sent++;
  endtask

  // stop sending until every pending result is out
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // setup and access phase, then psel and penable low again
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // new snap window with junk in the upper bits, then read it back
  task automatic set_window(input logic [9:0] w);
    drain_results();
    apb_access(APB_WRITE, SNAP_ADDR, {22'($urandom), w});
    apb_access(APB_READ, SNAP_ADDR, 32'd0);
    window_writes++;
  endtask

  // random pair, full range in half the draws, shaped cases in the rest
  task automatic pick_pair(output logic signed [15:0] ax, ay, bx, by);
    logic signed [15:0] dx, dy;
    ax = 16'($urandom);
    ay = 16'($urandom);
    bx = 16'($urandom);
    by = 16'($urandom);
    dx = rand_span(-4, 4);
    dy = rand_span(-4, 4);
    case ($urandom_range(0, 9))
      5: begin
        ax = rand_span(-8, 8);
        ay = rand_span(-8, 8);
        bx = rand_span(-8, 8);
        by = rand_span(-8, 8);
      end
      6: begin
        // collinear or perpendicular pairs
        ax = rand_span(-16383, 16383);
        ay = rand_span(-16383, 16383);
        case ($urandom_range(0, 4))
          0:       begin bx = ax;        by = ay;        end
          1:       begin bx = -ax;       by = -ay;       end
          2:       begin bx = -ay;       by = ax;        end
          3:       begin bx = ay;        by = -ax;       end
          default: begin bx = ax <<< 1;  by = ay <<< 1;  end
        endcase
      end
      7: begin
        // nearly parallel or antiparallel, around the snap points
        if ($urandom_range(0, 1) == 1) begin
          bx = ax + dx;
          by = ay + dy;
        end else begin
          bx = dx - ax;
          by = dy - ay;
        end
      end
      8: begin
        if ($urandom_range(0, 1) == 1) begin
          ax = '0;
          ay = '0;
        end else begin
          bx = '0;
          by = '0;
        end
      end
      9: begin
        ax = rand_edge();
        ay = rand_edge();
        bx = rand_edge();
        by = rand_edge();
      end
      default: ;
    endcase
  endtask

  // random phase; optional short gaps, stretches of back-to-back pairs, optional drain at the midpoint
  task automatic run_random(input int n, input bit with_gaps, input bit mid_drain);
    logic signed [15:0] ax, ay, bx, by;
    int                 calm;
    calm = 0;
    for (int i = 0; i < n; i++) begin
      pick_pair(ax, ay, bx, by);
      send_pair(ax, ay, bx, by);
      if (mid_drain && i == n / 2) begin
        drain_results();
      end else if (with_gaps) begin
        if (calm > 0) begin
          calm--;
        end else if ($urandom_range(0, 19) == 0) begin
          calm = $urandom_range(20, 60);
        end else if ($urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 7)) @(posedge clk_i);
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pairs under the reset window
    send_pair( 16'sd32767,  16'sd32767, -16'sd32768, -16'sd32768);
    send_pair(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_pair(-16'sd32768,  16'sd0,      16'sd0,     -16'sd32768);
    send_pair( 16'sd32767,  16'sd0,      16'sd0,     -16'sd32768);
    send_pair( 16'sd0,      16'sd0,      16'sd5,      16'sd7);
    send_pair( 16'sd3,     -16'sd4,      16'sd0,      16'sd0);
    send_pair( 16'sd0,      16'sd0,      16'sd0,      16'sd0);
    send_pair( 16'sd1,      16'sd0,      16'sd1,      16'sd1);
    send_pair( 16'sd1,      16'sd0,     -16'sd3,      16'sd2);
    send_pair( 16'sd1,      16'sd0,     -16'sd3,     -16'sd2);
    send_pair( 16'sd1,      16'sd0,      16'sd3,     -16'sd2);
    send_pair( 16'sd32767,  16'sd0,      16'sd32767,  16'sd1);
    send_pair( 16'sd32767,  16'sd0,      16'sd32767, -16'sd1);
    send_pair( 16'sd32767,  16'sd0,     -16'sd32767,  16'sd1);
    send_pair( 16'sd32767,  16'sd0,     -16'sd32767, -16'sd1);
    send_pair( 16'sd1000,   16'sd0,      16'sd1000,   16'sd1);
    send_pair( 16'sd1000,   16'sd0,      16'sd1000,   16'sd2);
    send_pair( 16'sd100,    16'sd0,      16'sd100,    16'sd2);
    send_pair(-16'sd32768,  16'sd32767,  16'sd32767, -16'sd32768);
    send_pair(-16'sd1,     -16'sd1,      16'sd32767, -16'sd32768);
    send_pair(-16'sd32768, -16'sd32768,  16'sd32767, -16'sd32768);
    send_pair( 16'sd0,      16'sd1,      16'sd1,      16'sd0);
    send_pair( 16'sd5,      16'sd0,      16'sd7,      16'sd0);
    send_pair( 16'sd5,      16'sd0,     -16'sd3,      16'sd0);
    send_pair( 16'sd12,     16'sd5,     -16'sd5,      16'sd12);

    // random phases across window settings
    set_window(10'd0);
    run_random(PHASE_ITEMS, 1'b1, 1'b0);
    set_window(10'd1023);
    run_random(PHASE_ITEMS, 1'b1, 1'b1);
    set_window(10'($urandom));
    run_random(PHASE_ITEMS, 1'b1, 1'b0);
    set_window(10'($urandom_range(1, 60)));
    apb_access(APB_WRITE, SPARE_ADDR, $urandom);
    run_random(PHASE_ITEMS, 1'b1, 1'b0);
    set_window(10'd10);
    run_random(PHASE_ITEMS, 1'b0, 1'b0);

    // drain, then watch for stray results
    drain_results();
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);

    $display("covered %0d vector pairs and %0d results over %0d snap window settings",
             pairs_sent, results_seen, window_writes + 1);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
